[hw/rtl/wildcard_byte_pattern_scan_defines.svh]
// Assertion macros used by the checker file of the wildcard byte pattern scan.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define WBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds across reset cycles.
`define WBPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/wbps_pkg.sv]
// Package with the constants, register codes and shared types of the pattern scan.
`timescale 1ns / 1ps
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int BYTE_W            = 8;
  localparam int PLEN_W            = 6;
  localparam int CNT_W             = 32;
  localparam int ADDR_W            = 64;
  localparam int CFG_W             = 64;
  localparam int CFG_IDX_W         = 3;
  localparam int NUM_PAT_WORDS     = 4;
  localparam int BYTES_PER_WORD    = 8;
  localparam int SH_W              = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'hCC;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = '1;
  localparam logic [PLEN_W-1:0] PLEN_RESET    = PLEN_W'(1);
  localparam logic [PLEN_W-1:0] PLEN_MAX      = PLEN_W'(MAX_PATTERN_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_0      = 3'd0,
    CFG_PATTERN_1      = 3'd1,
    CFG_PATTERN_2      = 3'd2,
    CFG_PATTERN_3      = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4,
    CFG_REGION_BASE    = 3'd5
  } cfg_reg_t;

  typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] byte_vec_t;
  typedef logic [MAX_PATTERN_BYTES-1:0]             flag_vec_t;

  // Settings seen by the datapath.
  typedef struct packed {
    byte_vec_t           pattern;   // pattern byte k at index k
    logic [PLEN_W-1:0]   len_eff;   // pattern length clamped to the window depth
    logic [ADDR_W-1:0]   base;
  } cfg_t;

  // Side information carried with the beat held in the window stage.
  typedef struct packed {
    logic              last;
    logic              chk;     // a match may be recorded on this beat
    logic [CNT_W-1:0]  start;   // offset where a match ending here begins
  } beat_meta_t;

endpackage

[hw/rtl/wildcard_byte_pattern_scan.sv]
// Top level of the wildcard byte pattern scan over a streamed memory region.
//
//   Channel   Direction  Content
//   in_*      sink       one region byte per beat, start flag in tuser, tlast ends region
//   out_*     source     one result per region: found in tuser, match address in tdata
//   cfg_*     sink       register writes: pattern words, pattern length, region base
//
// A byte is taken every cycle; the window stage and the result stage each hold one beat.
// A result is registered in the result stage once its last byte leaves the window stage and the output is free.
// The only backpressure is a result not yet taken: a last byte then waits in the window
// stage, and the input stalls behind it. Other bytes flow regardless of out_tready.
// Reset (rst_n low, synchronous) empties both stages and restores register defaults.
`timescale 1ns / 1ps
module wildcard_byte_pattern_scan
  import wbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] start_allowed
  input  logic                 in_tlast,   // last_byte
  // Result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ADDR_W-1:0]    out_tdata,  // [63:0] match_address
  output logic                 out_tuser   // [0] found
);

  cfg_t       cfg;
  byte_vec_t  byte_win;
  flag_vec_t  flag_win;
  beat_meta_t meta;
  logic       win_valid;
  logic       hit;
  logic       fire;
  logic       adv;
  logic       out_free;

  // The window stage hands its beat on unless it closes a region and the
  // output register still holds an untaken result.
  assign out_free  = !out_tvalid || out_tready;
  assign adv       = win_valid && (!meta.last || out_free);
  assign in_tready = !win_valid || adv;
  assign fire      = in_tvalid && in_tready;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbps_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .adv      (adv),
    .in_byte  (in_tdata),
    .in_flag  (in_tuser),
    .in_last  (in_tlast),
    .len_eff  (cfg.len_eff),
    .byte_win (byte_win),
    .flag_win (flag_win),
    .meta     (meta),
    .valid    (win_valid)
  );

  wbps_cmp u_cmp (
    .byte_win (byte_win),
    .flag_win (flag_win),
    .pattern  (cfg.pattern),
    .len_eff  (cfg.len_eff),
    .hit      (hit)
  );

  wbps_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .meta      (meta),
    .hit       (hit),
    .base      (cfg.base),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_found (out_tuser),
    .out_addr  (out_tdata)
  );

endmodule

[hw/rtl/wbps_cfg.sv]
// Configuration registers of the pattern scan and the settings derived from them.
`timescale 1ns / 1ps
module wbps_cfg
  import wbps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  logic [NUM_PAT_WORDS-1:0][CFG_W-1:0] pat_word_r;
  logic [PLEN_W-1:0]                   plen_r;
  logic [ADDR_W-1:0]                   base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_word_r <= '0;
      plen_r     <= PLEN_RESET;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_0:      pat_word_r[0] <= cfg_wdata;
        CFG_PATTERN_1:      pat_word_r[1] <= cfg_wdata;
        CFG_PATTERN_2:      pat_word_r[2] <= cfg_wdata;
        CFG_PATTERN_3:      pat_word_r[3] <= cfg_wdata;
        CFG_PATTERN_LENGTH: plen_r        <= cfg_wdata[PLEN_W-1:0];
        CFG_REGION_BASE:    base_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      cfg.pattern[k] = pat_word_r[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
    end
    cfg.len_eff = (plen_r > PLEN_MAX) ? PLEN_MAX : plen_r;
    cfg.base    = base_r;
  end

endmodule

[hw/rtl/wbps_window.sv]
// Input stage of the pattern scan: byte and start-flag windows, byte counter, beat info.
`timescale 1ns / 1ps
module wbps_window
  import wbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              adv,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_flag,
  input  logic              in_last,
  input  logic [PLEN_W-1:0] len_eff,
  output byte_vec_t         byte_win,
  output flag_vec_t         flag_win,
  output beat_meta_t        meta,
  output logic              valid
);

  byte_vec_t         byte_win_r, byte_win_nxt;
  flag_vec_t         flag_win_r, flag_win_nxt;
  logic [CNT_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  beat_meta_t        meta_r, meta_nxt;
  logic              valid_r;
  logic [PLEN_W-1:0] len_m1;

  always_comb begin
    byte_win_nxt[0] = in_byte;
    flag_win_nxt[0] = in_flag;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      byte_win_nxt[i] = byte_win_r[i-1];
      flag_win_nxt[i] = flag_win_r[i-1];
    end
  end

  // The new byte sits at offset bytes_seen_r; a match ending here starts len-1 earlier.
  always_comb begin
    len_m1         = len_eff - PLEN_W'(1);
    meta_nxt.last  = in_last;
    meta_nxt.chk   = (bytes_seen_r != COUNT_MAX) && (len_eff != '0) &&
                     (bytes_seen_r >= CNT_W'(len_m1));
    meta_nxt.start = bytes_seen_r - CNT_W'(len_m1);
    if (in_last) begin
      bytes_seen_nxt = '0;
    end else if (bytes_seen_r != COUNT_MAX) begin
      bytes_seen_nxt = bytes_seen_r + CNT_W'(1);
    end else begin
      bytes_seen_nxt = bytes_seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      bytes_seen_r <= '0;
    end else if (fire) begin
      valid_r      <= 1'b1;
      bytes_seen_r <= bytes_seen_nxt;
    end else if (adv) begin
      valid_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_win_r <= byte_win_nxt;
      flag_win_r <= flag_win_nxt;
      meta_r     <= meta_nxt;
    end
  end

  assign byte_win = byte_win_r;
  assign flag_win = flag_win_r;
  assign meta     = meta_r;
  assign valid    = valid_r;

endmodule

[hw/rtl/wbps_cmp.sv]
// Parallel compare of the byte window against the pattern with wildcard bytes.
`timescale 1ns / 1ps
module wbps_cmp
  import wbps_pkg::*;
(
  input  byte_vec_t         byte_win,
  input  flag_vec_t         flag_win,
  input  byte_vec_t         pattern,
  input  logic [PLEN_W-1:0] len_eff,
  output logic              hit
);

  // Reversing the window puts the oldest byte at index 0; shifting it down by
  // depth minus length then lines up pattern byte k with window byte len-1-k.
  byte_vec_t         rev_bytes, aligned_bytes;
  flag_vec_t         rev_flags, aligned_flags;
  logic [PLEN_W-1:0] sh_full;
  logic [SH_W-1:0]   sh;
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;

  always_comb begin
    for (int m = 0; m < MAX_PATTERN_BYTES; m++) begin
      rev_bytes[m] = byte_win[MAX_PATTERN_BYTES-1-m];
      rev_flags[m] = flag_win[MAX_PATTERN_BYTES-1-m];
    end
    sh_full       = PLEN_MAX - len_eff;
    sh            = sh_full[SH_W-1:0];
    aligned_bytes = rev_bytes >> {sh, 3'b000};
    aligned_flags = rev_flags >> sh;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      byte_ok[k] = (PLEN_W'(k) >= len_eff) || (pattern[k] == WILDCARD_BYTE) ||
                   (aligned_bytes[k] == pattern[k]);
    end
    hit = (len_eff != '0) && aligned_flags[0] && (&byte_ok);
  end

endmodule

[hw/rtl/wbps_result.sv]
// Result stage of the pattern scan: first-match tracking and the output register.
`timescale 1ns / 1ps
module wbps_result
  import wbps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  beat_meta_t        meta,
  input  logic              hit,
  input  logic [ADDR_W-1:0] base,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_found,
  output logic [ADDR_W-1:0] out_addr
);

  logic              seen_r;
  logic [CNT_W-1:0]  first_r;
  logic              out_valid_r;
  logic              found_r;
  logic [ADDR_W-1:0] addr_r;
  logic              hit_q;
  logic [ADDR_W-1:0] sum_first, sum_start;
  logic              found_nxt;
  logic [ADDR_W-1:0] addr_nxt;

  // Both candidate addresses are formed in parallel so the compare result only selects.
  always_comb begin
    hit_q     = meta.chk && hit;
    sum_first = base + ADDR_W'(first_r);
    sum_start = base + ADDR_W'(meta.start);
    found_nxt = seen_r || hit_q;
    if (seen_r) begin
      addr_nxt = sum_first;
    end else if (hit_q) begin
      addr_nxt = sum_start;
    end else begin
      addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        if (meta.last) begin
          seen_r <= 1'b0;
        end else if (hit_q && !seen_r) begin
          seen_r <= 1'b1;
        end
      end
      if (adv && meta.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !meta.last && hit_q && !seen_r) begin
      first_r <= meta.start;
    end
    if (adv && meta.last) begin
      found_r <= found_nxt;
      addr_r  <= addr_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = found_r;
  assign out_addr  = addr_r;

endmodule

[hw/rtl/wbps_checker.sv]
// Port-level checker of the pattern scan and its bind to the top level.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_defines.svh"
module wbps_checker
  import wbps_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tlast,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [ADDR_W-1:0]    out_tdata,
  input logic                 out_tuser
);

  `WBPS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat dropped or changed while stalled")
  `WBPS_ASSERT(a_miss_zero, out_tvalid && !out_tuser |-> out_tdata == '0, "no match but address is not zero")
  `WBPS_ASSERT(a_rise_after_last, $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2), "result without a closing byte two cycles earlier")
  `WBPS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[test/tb_top.sv]
// Self-checking testbench for the wildcard byte pattern scan, with a scoreboard predictor.
`timescale 1ns / 1ps
module tb_top;
  import wbps_pkg::*;

  // Register indexes that decode to nothing; writes there must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Cycles with no beat on either side before the run is declared hung. The longest
  // legitimate quiet stretch is the longest sender gap or receiver stall plus a few
  // register writes, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  // A result leaves only once its last byte has passed the window and result stages; wait
  // well past that before any register write so that no byte is still in the window stage.
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REGION     = 128;
  localparam int RANDOM_BEATS   = 1250;

  // One region report: found flag and match address.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_report_t;

  // Scoreboard: keeps its own copy of the registers and the scan state, predicts the
  // report of each region as its bytes are accepted, and checks reports in order.
  class pattern_match_model;
    logic [CFG_W-1:0]  pat_word [NUM_PAT_WORDS];
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] base;
    logic [BYTE_W-1:0] win_byte [MAX_PATTERN_BYTES];   // index 0 is the newest byte
    logic              win_start [MAX_PATTERN_BYTES];
    logic [CNT_W-1:0]  seen;
    logic              hit;
    logic [CNT_W-1:0]  hit_offset;
    scan_report_t      pending_reports [$];
    int                errors;

    function new();
      foreach (pat_word[i]) pat_word[i] = '0;
      plen   = PLEN_RESET;
      base   = '0;
      errors = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (win_byte[i]) begin
        win_byte[i]  = '0;
        win_start[i] = 1'b0;
      end
      seen       = '0;
      hit        = 1'b0;
      hit_offset = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_PATTERN_0, CFG_PATTERN_1, CFG_PATTERN_2, CFG_PATTERN_3: pat_word[idx] = val;
        CFG_PATTERN_LENGTH: plen = val[PLEN_W-1:0];
        CFG_REGION_BASE:    base = val;
        default: ;
      endcase
    endfunction

    // The newest byte is the last pattern byte; the oldest one must allow a start.
    function bit window_hit(int len);
      logic [BYTE_W-1:0] p;
      if (!win_start[len-1]) return 1'b0;
      for (int k = 0; k < len; k++) begin
        p = pat_word[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
        if (p != WILDCARD_BYTE && win_byte[len-1-k] != p) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] d, logic start_ok, logic last);
      logic [CNT_W-1:0] n;
      int               len;
      scan_report_t     rep;
      n   = seen;
      len = (plen > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(plen);
      for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) begin
        win_byte[i]  = win_byte[i-1];
        win_start[i] = win_start[i-1];
      end
      win_byte[0]  = d;
      win_start[0] = start_ok;
      // Once the byte counter saturates nothing more is recorded.
      if (n != COUNT_MAX) begin
        seen = n + 1'b1;
        if (!hit && len != 0 && n >= CNT_W'(len - 1) && window_hit(len)) begin
          hit        = 1'b1;
          hit_offset = n - CNT_W'(len - 1);
        end
      end
      if (last) begin
        rep.found = hit;
        rep.addr  = hit ? base + {{(ADDR_W-CNT_W){1'b0}}, hit_offset} : '0;
        pending_reports.push_back(rep);
        clear_region();
      end
    endfunction

    function void check_result(logic found, logic [ADDR_W-1:0] addr);
      scan_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected: found %0b address %h", $time, found, addr);
        return;
      end
      want = pending_reports.pop_front();
      if (found !== want.found) begin
        errors++;
        $display("%0t: found mismatch, expected %0b actual %0b", $time, want.found, found);
      end
      if (addr !== want.addr) begin
        errors++;
        $display("%0t: address mismatch, expected %h actual %h", $time, want.addr, addr);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata;   // [7:0] data_byte
  logic                 in_tuser;   // [0] start_allowed
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [ADDR_W-1:0]    out_tdata;  // [63:0] match_address
  logic                 out_tuser;  // [0] found

  pattern_match_model scan_model;

  // Pattern currently programmed, kept here so that stimulus can plant copies of it.
  logic [BYTE_W-1:0] cur_pat [MAX_PATTERN_BYTES];
  logic [PLEN_W-1:0] cur_len;
  // A few byte values per phase; data drawn from them hits the pattern by chance too.
  logic [BYTE_W-1:0] alpha [4];
  // When set, neither side inserts gaps or stalls.
  bit                steady;
  int                beats_sent;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  wildcard_byte_pattern_scan dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, mostly short with the odd long one, none while steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checking and the hang watchdog. Values are sampled at the edge, before the
  // nonblocking updates of that edge land, so the handshake seen here is the real one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) scan_model.check_result(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("wildcard_byte_pattern_scan verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One register write, then the enable is driven low again so that back-to-back calls
  // never assign the enable twice in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    scan_model.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pack_word(int w);
    logic [CFG_W-1:0] v;
    for (int b = 0; b < BYTES_PER_WORD; b++) v[b*BYTE_W +: BYTE_W] = cur_pat[w*BYTES_PER_WORD + b];
    return v;
  endfunction

  task automatic load_pattern();
    write_reg(CFG_PATTERN_0, pack_word(0));
    write_reg(CFG_PATTERN_1, pack_word(1));
    write_reg(CFG_PATTERN_2, pack_word(2));
    write_reg(CFG_PATTERN_3, pack_word(3));
    write_reg(CFG_PATTERN_LENGTH, CFG_W'(cur_len));
  endtask

  // Mostly short patterns; now and then zero length, full length or a value above
  // the window depth, which the block clamps.
  function automatic logic [PLEN_W-1:0] random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return '0;
    if (r < 70) return PLEN_W'($urandom_range(1, 6));
    if (r < 88) return PLEN_W'($urandom_range(7, 20));
    if (r < 96) return PLEN_W'($urandom_range(21, MAX_PATTERN_BYTES));
    return PLEN_W'($urandom_range(MAX_PATTERN_BYTES + 1, 63));
  endfunction

  // Drive one byte and hold it until it is taken. The prediction is updated right at
  // the accepting edge, in this process, so a later idle check cannot miss it.
  task automatic send_beat(input logic [BYTE_W-1:0] d, input logic start_ok, input logic last);
    int gap;
    int r;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= start_ok;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    scan_model.note_byte(d, start_ok, last);
    beats_sent++;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending, let every predicted report arrive, then let the pipeline drain.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (scan_model.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One region of random bytes. Most regions get a planted copy of the pattern (its
  // wildcards filled with random bytes), some of those with one byte spoiled, and a
  // few have the pattern length rewritten partway through.
  task automatic run_region(input int rlen);
    logic [BYTE_W-1:0] data [MAX_REGION];
    logic              flag [MAX_REGION];
    int                eff;
    int                off;
    int                k;
    int                change_at;
    eff = (cur_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(cur_len);
    for (int i = 0; i < rlen; i++) begin
      data[i] = ($urandom_range(0, 3) != 0) ? alpha[$urandom_range(0, 3)] : BYTE_W'($urandom);
      flag[i] = ($urandom_range(0, 99) < 85);
    end
    if (eff > 0 && rlen >= eff && $urandom_range(0, 99) < 65) begin
      off = $urandom_range(0, rlen - eff);
      for (int j = 0; j < eff; j++)
        data[off+j] = (cur_pat[j] == WILDCARD_BYTE) ? BYTE_W'($urandom) : cur_pat[j];
      flag[off] = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, eff - 1);
        data[off+k] = data[off+k] ^ BYTE_W'($urandom_range(1, 255));
      end
    end
    change_at = (rlen >= 4 && $urandom_range(0, 19) == 0) ? $urandom_range(1, rlen - 1) : -1;
    for (int i = 0; i < rlen; i++) begin
      if (i == change_at) begin
        // The block must be idle for a write, so the region pauses here.
        wait_idle();
        cur_len = random_length();
        write_reg(CFG_PATTERN_LENGTH, CFG_W'(cur_len));
      end
      send_beat(data[i], flag[i], i == rlen - 1);
    end
  endtask

  initial begin
    int               random_start;
    int               phase_end;
    int               eff;
    int               rlen;
    int               r;
    logic [ADDR_W-1:0] base_val;

    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_PATTERN_0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    steady     = 1'b0;
    beats_sent = 0;
    cur_len    = PLEN_RESET;
    foreach (cur_pat[i]) cur_pat[i] = '0;
    foreach (alpha[i]) alpha[i] = '0;
    scan_model = new();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a one-byte pattern of 0x00 at base zero matches a lone zero byte.
    send_beat(8'h00, 1'b1, 1'b1);
    wait_idle();

    // Pattern A5 ?? FF 00 with a base just below the top of the address space, plus
    // writes to the two unused indexes, which must change nothing.
    cur_pat[0] = 8'hA5;
    cur_pat[1] = WILDCARD_BYTE;
    cur_pat[2] = 8'hFF;
    cur_pat[3] = 8'h00;
    cur_len    = PLEN_W'(4);
    load_pattern();
    write_reg(CFG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CFG_SPARE_6, '1);
    write_reg(CFG_SPARE_7, {$urandom, $urandom});

    // Match at offset one, whose inner start flags are low.
    send_beat(8'h11, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'h77, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // Same bytes but the start flag of the would-be match is low: no match.
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // Region shorter than the pattern: no match.
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    // Match at offset zero, then the length drops to one mid-region; the later
    // one-byte match must not replace the first one.
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(8'h7E, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
    wait_idle();
    cur_len = PLEN_W'(1);
    write_reg(CFG_PATTERN_LENGTH, CFG_W'(cur_len));
    send_beat(8'hA5, 1'b1, 1'b1);
    wait_idle();

    // Zero pattern length never matches, even on the wildcard value itself.
    cur_len = '0;
    write_reg(CFG_PATTERN_LENGTH, CFG_W'(cur_len));
    send_beat(8'hA5, 1'b1, 1'b0);
    send_beat(WILDCARD_BYTE, 1'b1, 1'b1);
    wait_idle();

    // Base of all ones: a match at offset one wraps the address to zero.
    cur_len = PLEN_W'(1);
    write_reg(CFG_PATTERN_LENGTH, CFG_W'(cur_len));
    write_reg(CFG_REGION_BASE, '1);
    send_beat(8'h33, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b1);

    // Random phases: each picks a pattern, a length and maybe a base, then streams
    // regions until its share of bytes is done.
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      foreach (alpha[i]) alpha[i] = BYTE_W'($urandom);
      if ($urandom_range(0, 4) == 0) alpha[0] = WILDCARD_BYTE;
      cur_len = random_length();
      foreach (cur_pat[i]) begin
        r = $urandom_range(0, 99);
        cur_pat[i] = (r < 30) ? WILDCARD_BYTE :
                     (r < 90) ? alpha[$urandom_range(0, 3)] : BYTE_W'($urandom);
      end
      load_pattern();
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        base_val = (r < 15) ? '0 : (r < 30) ? '1 : {$urandom, $urandom};
        write_reg(CFG_REGION_BASE, base_val);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_6 : CFG_SPARE_7, {$urandom, $urandom});

      phase_end = beats_sent + $urandom_range(40, 150);
      while (beats_sent < phase_end) begin
        eff  = (cur_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(cur_len);
        rlen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, eff + 12)
                                            : $urandom_range(1, 2 * eff + 40);
        run_region(rlen);
        // Now and then hold the sender until every report is back.
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end

    wait_idle();
    if (scan_model.errors == 0) begin
      $display("wildcard_byte_pattern_scan verification clean");
    end else begin
      $display("wildcard_byte_pattern_scan verification failed");
    end
    $finish;
  end

endmodule
